### design/sped_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sped_pkg;

  // stream and field widths
  localparam int SAMPLE_W     = 16;
  localparam int PAT_W        = 16;
  localparam int MIN_LEN_W    = 24;
  localparam int EVT_LEN_W    = 24;

  // framing geometry
  localparam int HEADER_LEN   = 32;
  localparam int SKIP_LEN     = 9;
  localparam int PATTERN_LEN  = 4;
  localparam int LEN_BITS     = 24;

  // words the delay line holds at most (the line is one word deeper in the
  // stream sense, the newest word never sits in it before the decision)
  localparam int BUF_DEPTH    = HEADER_LEN + SKIP_LEN;
  localparam int BUF_AW       = $clog2(BUF_DEPTH);
  localparam int CNT_W        = $clog2(BUF_DEPTH + 1);
  localparam int HIST_CW      = $clog2(PATTERN_LEN + 1);

  // register map
  localparam int NUM_PAT_REGS = 4;
  localparam int NUM_REGS     = NUM_PAT_REGS + 1;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int PADDR_W      = REG_IDX_W + 2;
  localparam int PDATA_W      = 32;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = MIN_LEN_W'(30000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAT0    = REG_IDX_W'(0),
    REG_PAT1    = REG_IDX_W'(1),
    REG_PAT2    = REG_IDX_W'(2),
    REG_PAT3    = REG_IDX_W'(3),
    REG_MIN_LEN = REG_IDX_W'(4)
  } reg_idx_e;

  typedef struct packed {
    logic [NUM_PAT_REGS-1:0][PAT_W-1:0] pattern;
    logic [MIN_LEN_W-1:0]               min_len;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic step;   // take the offered word and run one framing step
    logic pop;    // flush the oldest buffered word as event data
    logic close;  // final verdict of a drained stream, then clear
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ofree;      // output register can be loaded this cycle
    logic eod_drain;  // offered word ends the stream inside an event
    logic more;       // more than one word left in the delay line
  } stat_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] data_word;
    logic                       keep;
    logic [EVT_LEN_W-1:0]       evt_len;
    logic                       last;
  } out_word_t;

endpackage

`default_nettype wire

### design/sped_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sped_in_if
  import sped_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_data;

  modport source (output valid, output sample, output end_of_data, input ready);
  modport sink   (input valid, input sample, input end_of_data, output ready);

endinterface

`default_nettype wire

### design/sped_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sped_out_if
  import sped_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] data_word;
  logic                       keep;
  logic [EVT_LEN_W-1:0]       evt_len;
  logic                       last;

  modport source (
    output valid, output kind, output data_word, output keep,
    output evt_len, output last, input ready
  );
  modport sink (
    input valid, input kind, input data_word, input keep,
    input evt_len, input last, output ready
  );

endinterface

`default_nettype wire

### design/sped_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sped_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 41
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/sped_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sped_regs
  import sped_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PAT0:    cfg_d.pattern[0] = pwdata[PAT_W-1:0];
        REG_PAT1:    cfg_d.pattern[1] = pwdata[PAT_W-1:0];
        REG_PAT2:    cfg_d.pattern[2] = pwdata[PAT_W-1:0];
        REG_PAT3:    cfg_d.pattern[3] = pwdata[PAT_W-1:0];
        REG_MIN_LEN: cfg_d.min_len    = pwdata[MIN_LEN_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAT0:    prdata = PDATA_W'(cfg_q.pattern[0]);
      REG_PAT1:    prdata = PDATA_W'(cfg_q.pattern[1]);
      REG_PAT2:    prdata = PDATA_W'(cfg_q.pattern[2]);
      REG_PAT3:    prdata = PDATA_W'(cfg_q.pattern[3]);
      REG_MIN_LEN: prdata = PDATA_W'(cfg_q.min_len);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.min_len <= MIN_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### design/sped_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sped_ctrl
  import sped_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire stat_t stat_i,
  output      logic  in_ready_o,
  output      cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_RUN   = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_RUN: begin
        in_ready_o = stat_i.ofree;
        cmd_o.step = in_valid_i && stat_i.ofree;
        if (cmd_o.step && stat_i.eod_drain) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.ofree) begin
          if (stat_i.more) begin
            cmd_o.pop = 1'b1;
          end else begin
            cmd_o.close = 1'b1;
            state_d     = S_RUN;
          end
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/sped_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sped_dp
  import sped_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  input  wire cfg_t                       cfg_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       eod_i,
  input  wire logic                       out_ready_i,
  output      stat_t                      stat_o,
  output      logic                       out_valid_o,
  output      out_word_t                  out_o
);

  localparam logic [EVT_LEN_W-1:0] EVT_MAX = {EVT_LEN_W{1'b1}};

  // pattern history
  logic [PATTERN_LEN-1:0][PAT_W-1:0] hist_q, hist_d, hist_new;
  logic [HIST_CW-1:0]                hfill_q, hfill_d, hfill_new;
  logic                              match;

  // delay line bookkeeping
  logic [BUF_AW-1:0] head_q, head_d, head_inc, tail;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W:0]    tail_sum;
  logic              full;

  // event state
  logic                in_event_q, in_event_d;
  logic [LEN_BITS-1:0] length_q, length_d, len_inc;
  logic                keep_now;
  logic [63:0]         len_wide;
  logic [EVT_LEN_W-1:0] len_out;

  // output register
  logic      out_vld_q, out_vld_d, load;
  out_word_t out_q, out_d;

  // ram
  logic                we;
  logic [SAMPLE_W-1:0] rd_data;

  always_comb begin
    for (int k = 0; k < PATTERN_LEN - 1; k++) begin
      hist_new[k] = hist_q[k+1];
    end
    hist_new[PATTERN_LEN-1] = sample_i;
    hfill_new = (hfill_q == HIST_CW'(PATTERN_LEN)) ? hfill_q : hfill_q + HIST_CW'(1);
    match = (hfill_new == HIST_CW'(PATTERN_LEN));
    for (int k = 0; k < PATTERN_LEN; k++) begin
      if (hist_new[k] != cfg_i.pattern[k]) begin
        match = 1'b0;
      end
    end
  end

  assign full     = (count_q == CNT_W'(BUF_DEPTH));
  assign head_inc = (head_q == BUF_AW'(BUF_DEPTH - 1)) ? '0 : head_q + BUF_AW'(1);
  assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
  assign tail     = (tail_sum >= (CNT_W+1)'(BUF_DEPTH)) ?
                    BUF_AW'(tail_sum - (CNT_W+1)'(BUF_DEPTH)) : BUF_AW'(tail_sum);

  assign len_inc  = (length_q == {LEN_BITS{1'b1}}) ? length_q : length_q + LEN_BITS'(1);
  assign keep_now = (32'(length_q) >= 32'(cfg_i.min_len));
  assign len_wide = 64'(length_q);
  assign len_out  = (len_wide > 64'(EVT_MAX)) ? EVT_MAX : EVT_LEN_W'(len_wide);

  assign stat_o.ofree     = !out_vld_q || out_ready_i;
  assign stat_o.eod_drain = eod_i && (match || in_event_q);
  assign stat_o.more      = (count_q > CNT_W'(1));

  always_comb begin
    hist_d     = hist_q;
    hfill_d    = hfill_q;
    head_d     = head_q;
    count_d    = count_q;
    in_event_d = in_event_q;
    length_d   = length_q;
    we         = 1'b0;
    load       = 1'b0;
    out_d      = out_q;

    if (cmd_i.step) begin
      hist_d  = hist_new;
      hfill_d = hfill_new;
      if (match) begin
        // header found: buffered words are header, a verdict closes the open event
        if (in_event_q) begin
          load            = 1'b1;
          out_d.kind      = 1'b1;
          out_d.data_word = '0;
          out_d.keep      = keep_now;
          out_d.evt_len   = len_out;
          out_d.last      = !eod_i;
        end
        in_event_d = 1'b1;
        length_d   = '0;
        count_d    = '0;
      end else begin
        we = 1'b1;
        if (full) begin
          head_d = head_inc;
          if (in_event_q) begin
            load            = 1'b1;
            out_d.kind      = 1'b0;
            out_d.data_word = $signed(rd_data);
            out_d.keep      = 1'b0;
            out_d.evt_len   = '0;
            out_d.last      = !eod_i;
            length_d        = len_inc;
          end
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      if (eod_i) begin
        hist_d  = '0;
        hfill_d = '0;
        if (!(match || in_event_q)) begin
          // stream ends with no header seen: drop everything
          count_d    = '0;
          in_event_d = 1'b0;
          length_d   = '0;
        end
      end
    end

    if (cmd_i.pop) begin
      load            = 1'b1;
      out_d.kind      = 1'b0;
      out_d.data_word = $signed(rd_data);
      out_d.keep      = 1'b0;
      out_d.evt_len   = '0;
      out_d.last      = 1'b0;
      length_d        = len_inc;
      head_d          = head_inc;
      count_d         = count_q - CNT_W'(1);
    end

    if (cmd_i.close) begin
      load            = 1'b1;
      out_d.kind      = 1'b1;
      out_d.data_word = '0;
      out_d.keep      = keep_now;
      out_d.evt_len   = len_out;
      out_d.last      = 1'b1;
      count_d         = '0;
      in_event_d      = 1'b0;
      length_d        = '0;
    end

    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // read address runs one step ahead so the oldest word is always waiting
  sped_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUF_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail),
    .wdata_i (sample_i),
    .raddr_i (head_d),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hfill_q    <= '0;
      head_q     <= '0;
      count_q    <= '0;
      in_event_q <= 1'b0;
      length_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      hfill_q    <= hfill_d;
      head_q     <= head_d;
      count_q    <= count_d;
      in_event_q <= in_event_d;
      length_q   <= length_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(BUF_DEPTH))
    else $error("delay line count out of range");

  a_pop_in_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (in_event_q && count_q > CNT_W'(1)))
    else $error("flush outside an open event");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |-> !load)
    else $error("output word overwritten while stalled");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |=> (count_q == '0 && !in_event_q && length_q == '0))
    else $error("stream state not cleared after final verdict");
`endif

endmodule

`default_nettype wire

### design/sync_pattern_event_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake        payload
// in_ch     in    valid / ready    sample (s16), end_of_data
// out_ch    out   valid / ready    kind, data_word (s16), keep, evt_len (24), last
// apb       in    psel/penable     pattern words 0..3 at 0x00..0x0c, minimum length at 0x10
//
// one input word per clock while the output word register drains and no end-of-data
// drain runs, a word leaves as event data or as a verdict through that single register
// end of data inside an open event flushes the buffered words one at a time and then
// sends the verdict, paced by the delay line ram read port
// async active-low reset clears the framing state, patterns go to 0 and
// the minimum length to 30000
// a stalled output word holds the input off until it is taken

module sync_pattern_event_deframer
  import sped_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  sped_in_if.sink                 in_ch,
  sped_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  cfg_t      cfg;
  cmd_t      cmd;
  stat_t     stat;
  out_word_t out_word;
  logic      out_valid;

  // configuration registers
  sped_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencing: normal stepping and the end-of-data drain
  sped_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .stat_i     (stat),
    .in_ready_o (in_ch.ready),
    .cmd_o      (cmd)
  );

  // sync match, delay line, length count and output word register
  sped_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .sample_i    (in_ch.sample),
    .eod_i       (in_ch.end_of_data),
    .out_ready_i (out_ch.ready),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_o       (out_word)
  );

  assign out_ch.valid     = out_valid;
  assign out_ch.kind      = out_word.kind;
  assign out_ch.data_word = out_word.data_word;
  assign out_ch.keep      = out_word.keep;
  assign out_ch.evt_len   = out_word.evt_len;
  assign out_ch.last      = out_word.last;

endmodule

`default_nettype wire

### test/tb_sync_pattern_event_deframer.sv
`timescale 1ns / 1ps

module tb_sync_pattern_event_deframer;
  import sped_pkg::*;

  // stream geometry as the block sees it: the current word plus header and skip
  localparam int LINE_DEPTH = HEADER_LEN + SKIP_LEN + 1;
  localparam longint unsigned LEN_SAT = (64'd1 << LEN_BITS) - 1;
  localparam longint unsigned OUT_LEN_SAT = (64'd1 << EVT_LEN_W) - 1;

  // a drain runs on after the last word is taken, so settling waits past it
  localparam int SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int NUM_PHASES = 4;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,    // predicted words
    CHK_NONE,     // no word at all
    CHK_VERDICT   // exactly one verdict, typed in the row
  } row_chk_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                eod;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic                 eod;
    row_chk_e             chk;
    logic                 keep;
    logic [EVT_LEN_W-1:0] len;
  } dir_row_t;

  // rows from SEG2_START on run with pattern 8000 7fff ffff 0000 and minimum 0
  localparam int N_DIR = 24;
  localparam int SEG2_START = 14;

  dir_row_t directed_rows [N_DIR] = '{
    // reset config: pattern all zero, minimum 30000
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},  // short stream start, no match yet
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},  // first header, no verdict
    '{16'h7fff, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h8000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'hffff, 1'b1, CHK_MODEL,   1'b0, 24'd0},  // end of data, flush and verdict
    '{16'h1234, 1'b1, CHK_NONE,    1'b0, 24'd0},  // end of data with no header
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},  // header again
    '{16'h0000, 1'b0, CHK_VERDICT, 1'b0, 24'd0},  // overlapping header, empty event cut
    '{16'h0000, 1'b1, CHK_MODEL,   1'b0, 24'd0},  // match on the final word
    // extreme pattern words, minimum 0
    '{16'h8000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h7fff, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'hffff, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b0, CHK_NONE,    1'b0, 24'd0},  // first header
    '{16'h5a5a, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'ha5a5, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h8000, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h7fff, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'hffff, 1'b0, CHK_NONE,    1'b0, 24'd0},
    '{16'h0000, 1'b1, CHK_MODEL,   1'b0, 24'd0}   // header words discarded, two kept verdicts
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sped_in_if  in_ch ();
  sped_out_if out_ch ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sync_pattern_event_deframer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // framing state of the predictor
  logic [SAMPLE_W-1:0] line_words [LINE_DEPTH];
  int                  fill_words;
  bit                  event_open;
  longint unsigned     run_length;
  logic [SAMPLE_W-1:0] recent [PATTERN_LEN];
  int                  recent_fill;

  // register copies
  logic [PAT_W-1:0]     sync_pattern [NUM_PAT_REGS];
  logic [MIN_LEN_W-1:0] min_length;

  out_word_t expected_words [$];
  out_word_t step_words [$];
  in_word_t  stream_words [$];

  int errors = 0;
  int items_taken = 0;
  int data_checked = 0;
  int verdicts_checked = 0;
  int kept_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic void restart_stream();
    foreach (line_words[k]) line_words[k] = '0;
    foreach (recent[k]) recent[k] = '0;
    fill_words = 0;
    event_open = 1'b0;
    run_length = 0;
    recent_fill = 0;
  endfunction

  function automatic void emit_data(logic [SAMPLE_W-1:0] w);
    out_word_t d;
    d = '0;
    d.kind = KIND_DATA;
    d.data_word = w;
    step_words.insert(step_words.size(), d);
    if (run_length < LEN_SAT) run_length++;
  endfunction

  function automatic void emit_verdict();
    out_word_t v;
    v = '0;
    v.kind = KIND_VERDICT;
    v.keep = (run_length >= min_length);
    v.evt_len = (run_length > OUT_LEN_SAT) ? EVT_LEN_W'(OUT_LEN_SAT) : EVT_LEN_W'(run_length);
    step_words.insert(step_words.size(), v);
  endfunction

  // one framing step, leaves the words this input causes in step_words
  function automatic void deframe_step(logic [SAMPLE_W-1:0] w, logic eod);
    bit hit;
    int k;
    hit = 1'b1;
    step_words.delete();
    for (k = 0; k < PATTERN_LEN - 1; k++) recent[k] = recent[k+1];
    recent[PATTERN_LEN-1] = w;
    if (recent_fill < PATTERN_LEN) recent_fill++;
    if (recent_fill < PATTERN_LEN) hit = 1'b0;
    for (k = 0; k < PATTERN_LEN && k < NUM_PAT_REGS; k++)
      if (recent[k] !== sync_pattern[k]) hit = 1'b0;

    if (hit) begin
      // header found: the buffered words were header or skip words
      if (event_open) emit_verdict();
      event_open = 1'b1;
      run_length = 0;
      fill_words = 0;
    end else begin
      if (fill_words >= LINE_DEPTH - 1) begin
        if (event_open) emit_data(line_words[0]);
        for (k = 0; k < LINE_DEPTH - 1; k++) line_words[k] = line_words[k+1];
        fill_words = LINE_DEPTH - 2;
      end
      line_words[fill_words] = w;
      fill_words++;
    end

    if (eod) begin
      // flush all but the final word, then close
      if (event_open) begin
        for (k = 0; k + 1 < fill_words; k++) emit_data(line_words[k]);
        emit_verdict();
      end
      restart_stream();
    end

    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
  endfunction

  function automatic string show(out_word_t w);
    return $sformatf("kind %0d data %0d keep %0d length %0d last %0d",
                     w.kind, w.data_word, w.keep, w.evt_len, w.last);
  endfunction

  function automatic void push_noise();
    stream_words.insert(stream_words.size(), {16'($urandom()), 1'b0});
  endfunction

  // one stream: noise only, or lead-in noise, maybe a broken pattern, then events, closed by end of data
  function automatic void build_stream();
    int lead;
    int n_events;
    int payload;
    int cut;
    int sel;
    int e;
    int k;
    stream_words.delete();
    if ($urandom_range(0, 7) == 0) begin
      // noise only, block should stay silent
      lead = $urandom_range(1, 10);
      repeat (lead) push_noise();
    end else begin
      lead = $urandom_range(0, 6);
      repeat (lead) push_noise();
      if ($urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, PATTERN_LEN - 1);
        for (k = 0; k < cut; k++)
          stream_words.insert(stream_words.size(), {sync_pattern[k], 1'b0});
        push_noise();
      end
      n_events = $urandom_range(1, 2);
      for (e = 0; e < n_events; e++) begin
        for (k = 0; k < PATTERN_LEN; k++)
          stream_words.insert(stream_words.size(), {sync_pattern[k], 1'b0});
        sel = $urandom_range(0, 9);
        if (sel < 3) payload = $urandom_range(0, 3);        // overlapping headers
        else if (sel < 8) payload = $urandom_range(4, 30);  // short events, flushed at end
        else payload = $urandom_range(40, 60);              // words pass the delay line
        if (e == n_events - 1 && $urandom_range(0, 4) == 0) payload = 0;
        repeat (payload) push_noise();
      end
    end
    stream_words[stream_words.size()-1].eod = 1'b1;
  endfunction

  // offer one word, with random gaps before it, and predict once it is taken
  task automatic send_word(input in_word_t item, input row_chk_e chk,
                           input logic keep, input logic [EVT_LEN_W-1:0] len);
    out_word_t v;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= item.sample;
    in_ch.end_of_data <= item.eod;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_taken++;
    deframe_step(item.sample, item.eod);
    case (chk)
      CHK_MODEL: begin
        foreach (step_words[k]) expected_words.insert(expected_words.size(), step_words[k]);
      end
      CHK_VERDICT: begin
        v = '0;
        v.kind = KIND_VERDICT;
        v.keep = keep;
        v.evt_len = len;
        v.last = 1'b1;
        expected_words.insert(expected_words.size(), v);
      end
      default: ;
    endcase
  endtask

  // sender stops until every expected word is out, then lets the block go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup, access, register written at the access edge
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MIN_LEN) min_length = value[MIN_LEN_W-1:0];
    else sync_pattern[idx] = value[PAT_W-1:0];
    @(posedge clk_i);
  endtask

  // output side: check each taken word against the oldest prediction, stall at random
  initial begin
    out_word_t got;
    out_word_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.data_word, out_ch.keep, out_ch.evt_len, out_ch.last};
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %s", $time, show(got));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch, expected %s, actual %s", $time, show(want), show(got));
          end else if (got.kind == KIND_DATA) begin
            data_checked++;
          end else begin
            verdicts_checked++;
            if (got.keep) kept_checked++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    int phase_items;
    int r;
    bit first_stream;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.end_of_data <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    foreach (sync_pattern[k]) sync_pattern[k] = '0;
    min_length = MIN_LEN_RST;
    restart_stream();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, first part on the reset config
    for (r = 0; r < N_DIR; r++) begin
      if (r == SEG2_START) begin
        settle();
        write_reg(REG_PAT0, 32'h8000);
        write_reg(REG_PAT1, 32'h7fff);
        write_reg(REG_PAT2, 32'hffff);
        write_reg(REG_PAT3, 32'h0000);
        write_reg(REG_MIN_LEN, 32'd0);
      end
      send_word({directed_rows[r].sample, directed_rows[r].eod}, directed_rows[r].chk,
                directed_rows[r].keep, directed_rows[r].len);
    end
    settle();

    // random streams: no gaps, idle sender, stalling receiver, both
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      write_reg(REG_PAT0, 32'($urandom_range(0, 65535)));
      write_reg(REG_PAT1, 32'($urandom_range(0, 65535)));
      write_reg(REG_PAT2, 32'($urandom_range(0, 65535)));
      write_reg(REG_PAT3, 32'($urandom_range(0, 65535)));
      // first phase cuts every event, the others straddle the event lengths
      if (phase == 0) write_reg(REG_MIN_LEN, 32'hffffff);
      else write_reg(REG_MIN_LEN, 32'($urandom_range(0, 40)));

      phase_items = 0;
      first_stream = 1'b1;
      while (phase_items < ITEMS_PER_PHASE) begin
        build_stream();
        foreach (stream_words[k]) send_word(stream_words[k], CHK_MODEL, 1'b0, '0);
        phase_items += stream_words.size();
        if (first_stream) begin
          // hold the sender until the output side has caught up
          settle();
          first_stream = 1'b0;
        end
      end
      settle();
    end

    $display("%0d input words taken; %0d data words and %0d verdicts (%0d kept) matched",
             items_taken, data_checked, verdicts_checked, kept_checked);
    $display("directed framing cases plus random streams under four idle and stall mixes");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/sped_pkg.sv
design/sped_in_if.sv
design/sped_out_if.sv
design/sped_ram.sv
design/sped_regs.sv
design/sped_ctrl.sv
design/sped_dp.sv
design/sync_pattern_event_deframer.sv
test/tb_sync_pattern_event_deframer.sv
